// ===== rtl/rbi_pkg.sv =====
package rbi_pkg;

  localparam int AXES        = 3;
  localparam int QW          = 32;
  localparam int FRAC        = 16;
  localparam int DVD_W       = QW + FRAC;
  localparam int DIV_STAGES  = DVD_W;
  localparam int MID_DEPTH   = 2;
  localparam int MID_AW      = $clog2(MID_DEPTH);
  localparam int MID_CW      = $clog2(MID_DEPTH + 1);

  localparam logic signed [QW-1:0] T_NONE = -32'sd65536;
  localparam logic signed [QW-1:0] Q_MAX  = 32'sh7fffffff;
  localparam logic signed [QW-1:0] Q_MIN  = 32'sh80000000;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z,
    AXIS_INSIDE
  } axis_t;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    q_t origin_x;
    q_t origin_y;
    q_t origin_z;
    q_t dir_x;
    q_t dir_y;
    q_t dir_z;
    q_t box_min_x;
    q_t box_min_y;
    q_t box_min_z;
    q_t box_max_x;
    q_t box_max_y;
    q_t box_max_z;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic       origin_inside;
    q_t         hit_x;
    q_t         hit_y;
    q_t         hit_z;
    logic [1:0] hit_axis;
  } out_t;

  typedef struct packed {
    logic [AXES-1:0][QW-1:0] org;
    logic [AXES-1:0][QW-1:0] dir;
    logic [AXES-1:0][QW-1:0] lo;
    logic [AXES-1:0][QW-1:0] hi;
    logic [AXES-1:0][QW-1:0] plane;
    logic [AXES-1:0]         outside;
    logic [AXES-1:0]         num_neg;
    logic                    all_in;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic [AXES-1:0][QW-1:0] num_mag;
  } mid_t;

endpackage

// ===== rtl/rbi_front.sv =====
module rbi_front (
  input  rbi_pkg::in_t  ray,
  output rbi_pkg::mid_t item
);
  import rbi_pkg::*;

  logic [AXES-1:0][QW-1:0] org, dir, lo, hi;

  assign org = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign dir = {ray.dir_z, ray.dir_y, ray.dir_x};
  assign lo  = {ray.box_min_z, ray.box_min_y, ray.box_min_x};
  assign hi  = {ray.box_max_z, ray.box_max_y, ray.box_max_x};

  always_comb begin
    logic [QW:0] diff;
    item = '0;
    for (int i = 0; i < AXES; i++) begin
      item.side.org[i] = org[i];
      item.side.dir[i] = dir[i];
      item.side.lo[i]  = lo[i];
      item.side.hi[i]  = hi[i];
      // below-min is tested first, so an inverted box never counts as between
      if ($signed(org[i]) < $signed(lo[i])) begin
        item.side.plane[i]   = lo[i];
        item.side.outside[i] = 1'b1;
      end else if ($signed(org[i]) > $signed(hi[i])) begin
        item.side.plane[i]   = hi[i];
        item.side.outside[i] = 1'b1;
      end else begin
        item.side.plane[i]   = '0;
        item.side.outside[i] = 1'b0;
      end
      diff = {item.side.plane[i][QW-1], item.side.plane[i]} - {org[i][QW-1], org[i]};
      item.side.num_neg[i] = diff[QW];
      item.num_mag[i]      = diff[QW] ? QW'(-diff) : diff[QW-1:0];
    end
    item.side.all_in = ~|item.side.outside;
  end

endmodule

// ===== rtl/rbi_queue.sv =====
module rbi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  rbi_pkg::mid_t wdata,
  output logic          full,
  input  logic          rd,
  output rbi_pkg::mid_t rdata,
  output logic          empty
);
  import rbi_pkg::*;

  mid_t              mem [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr, rd_ptr;
  logic [MID_CW-1:0] count;
  logic              do_wr, do_rd;

  assign full  = (count == MID_CW'(MID_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + MID_CW'(do_wr) - MID_CW'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wdata;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MID_CW'(MID_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on read");

endmodule

// ===== rtl/rbi_div.sv =====
module rbi_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rbi_pkg::DVD_W-1:0] dividend,
  input  logic [rbi_pkg::QW-1:0]    divisor,
  output logic [rbi_pkg::DVD_W-1:0] quotient
);
  import rbi_pkg::*;

  // one quotient bit per stage, restoring
  logic [QW-1:0]    rem [DIV_STAGES];
  logic [DVD_W-1:0] quo [DIV_STAGES];
  logic [DVD_W-1:0] dvd [DIV_STAGES];
  logic [QW-1:0]    dsr [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [QW-1:0]    r_in, d_in;
    logic [DVD_W-1:0] q_in, x_in;
    logic [QW:0]      r_sh;
    logic             take;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign d_in = divisor;
      assign q_in = '0;
      assign x_in = dividend;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign d_in = dsr[k-1];
      assign q_in = quo[k-1];
      assign x_in = dvd[k-1];
    end

    assign r_sh = {r_in, x_in[DVD_W-1]};
    assign take = (r_sh >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? QW'(r_sh - {1'b0, d_in}) : r_sh[QW-1:0];
        quo[k] <= {q_in[DVD_W-2:0], take};
        dvd[k] <= {x_in[DVD_W-2:0], 1'b0};
        dsr[k] <= d_in;
      end
    end
  end

  assign quotient = quo[DIV_STAGES-1];

endmodule

// ===== rtl/rbi_back.sv =====
module rbi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rbi_pkg::mid_t item,
  output logic          take,
  output rbi_pkg::out_t result,
  output logic          out_valid,
  input  logic          pop
);
  import rbi_pkg::*;

  logic en;
  assign en   = !out_valid || pop;
  assign take = en;

  // divider stages
  logic [DIV_STAGES-1:0]         dv;
  side_t                         dside [DIV_STAGES];
  logic [AXES-1:0][DVD_W-1:0]    q;

  always_ff @(posedge clk) begin
    if (rst) dv <= '0;
    else if (en) dv <= {dv[DIV_STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= item.side;
      for (int k = 1; k < DIV_STAGES; k++) dside[k] <= dside[k-1];
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    logic [QW-1:0] dmag;
    assign dmag = item.side.dir[a][QW-1] ? -item.side.dir[a] : item.side.dir[a];
    rbi_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend ({item.num_mag[a], FRAC'(0)}),
      .divisor  (dmag),
      .quotient (q[a])
    );
  end

  // stage A: sign, saturation, sentinel
  side_t                  sa;
  logic                   va;
  logic [AXES-1:0][QW-1:0] ta, ta_next;

  always_comb begin
    side_t s;
    logic  neg;
    s = dside[DIV_STAGES-1];
    for (int i = 0; i < AXES; i++) begin
      neg = s.num_neg[i] ^ s.dir[i][QW-1];
      if (!s.outside[i] || s.dir[i] == '0) ta_next[i] = T_NONE;
      else if (!neg) ta_next[i] = (q[i] > DVD_W'(Q_MAX)) ? Q_MAX : q[i][QW-1:0];
      else ta_next[i] = (q[i] > (DVD_W'(1) << (QW-1))) ? Q_MIN : -q[i][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= dv[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= dside[DIV_STAGES-1];
      ta <= ta_next;
    end
  end

  // stage B: largest t, lower axis wins ties
  side_t      sb;
  logic       vb;
  logic [1:0] bb, bb_next;
  q_t         tb;

  always_comb begin
    bb_next = 2'(AXIS_X);
    if ($signed(ta[0]) < $signed(ta[1])) bb_next = 2'(AXIS_Y);
    if ($signed(ta[bb_next]) < $signed(ta[2])) bb_next = 2'(AXIS_Z);
  end

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb <= sa;
      bb <= bb_next;
      tb <= ta[bb_next];
    end
  end

  // stage C: t * dir on each axis
  side_t                     sc;
  logic                      vc, missc;
  logic [1:0]                bc;
  logic signed [2*QW-1:0]    prod [AXES];

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc    <= sb;
      bc    <= bb;
      missc <= tb[QW-1];
      for (int i = 0; i < AXES; i++) prod[i] <= tb * $signed(sb.dir[i]);
    end
  end

  // stage D: hit point and box check into the output register
  out_t result_next;

  always_comb begin
    logic signed [2*QW-1:0] pt;
    logic                   ok;
    logic [AXES-1:0][QW-1:0] hp;
    ok = !missc;
    hp = '0;
    for (int i = 0; i < AXES; i++) begin
      pt = $signed(sc.org[i]) + (prod[i] >>> FRAC);
      if (bc == 2'(i)) begin
        hp[i] = sc.plane[i];
      end else begin
        hp[i] = pt[QW-1:0];
        if (pt < $signed(sc.lo[i]) || pt > $signed(sc.hi[i])) ok = 1'b0;
      end
    end
    result_next = '0;
    if (sc.all_in) begin
      result_next.hit           = 1'b1;
      result_next.origin_inside = 1'b1;
      result_next.hit_x         = sc.org[0];
      result_next.hit_y         = sc.org[1];
      result_next.hit_z         = sc.org[2];
      result_next.hit_axis      = 2'(AXIS_INSIDE);
    end else if (ok) begin
      result_next.hit      = 1'b1;
      result_next.hit_x    = hp[0];
      result_next.hit_y    = hp[1];
      result_next.hit_z    = hp[2];
      result_next.hit_axis = bc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vc;
  end

  always_ff @(posedge clk) begin
    if (en) result <= result_next;
  end

endmodule

// ===== rtl/ray_box_intersection.sv =====
// Ray / axis-aligned box intersection, signed Q16.16.
//
// Input queue side: drive ray and push; the item is taken on a clock edge
// with push high and full low. Result queue side: while empty is low the
// oldest result sits on result; pop with empty low takes it.
//
// One result per item, in order. Between the queue and the output, an item
// passes the 48-stage pipelined divider (one quotient bit per stage), then
// sign/saturation, select and multiply stages, and the box check into the
// output register. One item enters per cycle unless the back pipeline holds.
//
// When pop stays low with a result waiting, the back pipeline holds and the
// two-entry queue behind the classifier keeps taking items until it fills,
// then full rises.
//
// Synchronous active-high rst empties both queues and the pipeline; no
// result is lost or invented by a stall.
module ray_box_intersection (
  input  logic          clk,
  input  logic          rst,
  input  rbi_pkg::in_t  ray,
  input  logic          push,
  output logic          full,
  output rbi_pkg::out_t result,
  output logic          empty,
  input  logic          pop
);
  import rbi_pkg::*;

  mid_t fitem, qitem;
  logic q_empty, take, out_valid;

  rbi_front u_front (
    .ray  (ray),
    .item (fitem)
  );

  rbi_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (fitem),
    .full  (full),
    .rd    (take),
    .rdata (qitem),
    .empty (q_empty)
  );

  rbi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .item      (qitem),
    .take      (take),
    .result    (result),
    .out_valid (out_valid),
    .pop       (pop)
  );

  assign empty = !out_valid;

endmodule
